// ===== rtl/core/humidity_temp_frame_decoder_macros.svh =====
// Assertion macros for the humidity and temperature frame decoder.
// Used by humidity_temp_frame_decoder.sv; no other dependencies.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define HTFD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("htfd assertion failed");
`define HTFD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("htfd assertion failed");
`else
`define HTFD_ASSERT(name, clk, rstn, prop)
`define HTFD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== rtl/core/htfd_pkg.sv =====
// Constants and the CRC-8 byte step for the humidity and temperature decoder.
// No dependencies.
`timescale 1ns / 1ps

package htfd_pkg;

    localparam logic [7:0]         CRC_POLY   = 8'h31;
    localparam logic [7:0]         CRC_INIT   = 8'hFF;
    localparam logic [16:0]        FULL_SCALE = 17'd65535;
    localparam logic [15:0]        ROUND_BIAS = 16'd32767;
    localparam logic [14:0]        TEMP_SPAN  = 15'd17500;
    localparam logic [13:0]        HUM_SPAN   = 14'd10000;
    localparam logic signed [16:0] TEMP_BASE  = -17'sd4500;
    localparam logic signed [16:0] HUM_MAX    = 17'sd10000;

    localparam logic REG_TEMP_OFFSET = 1'b0;
    localparam logic REG_HUM_OFFSET  = 1'b1;

    // One byte of CRC-8, MSB first, no final xor.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/humidity_temp_frame_decoder.sv =====
// Humidity and temperature frame decoder: top level, three-stage pipeline.
// Depends on htfd_pkg and humidity_temp_frame_decoder_macros.svh.
//
// Usage:
//   s_ channel: one request is one sensor frame (two raw words, two CRC bytes).
//   m_ channel: one result per request: temperature in 0.01 degC, humidity
//   in 0.01 %RH clipped to 0..10000, and check_error when either CRC byte
//   does not match.
//   APB port: register 0 (address 0) temp_offset, register 1 (address 4)
//   hum_offset; both signed, reset to zero; the user writes them only while
//   the block is idle, which the block itself does not enforce.
// Path: a request is registered in stage 1, then stage 2, then stage 3; m_valid is the stage 3 valid.
// Throughput: one request per cycle while m_ready is high; the stages are the
//   constant multiply with the first CRC byte, the reciprocal divide by 65535
//   with the second CRC byte, and the offset add with the clip.
// Stall: each stage holds while the one after it is full and stalled; s_ready
//   stays high while any bubble is left, so up to three requests are held.
// Reset: synchronous, active low; all stages empty, offsets zero.
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_macros.svh"

module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_temp_raw,
    input  logic [7:0]         s_temp_check,
    input  logic [15:0]        s_hum_raw,
    input  logic [7:0]         s_hum_check,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_temperature,
    output logic [13:0]        m_humidity,
    output logic               m_check_error,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic signed [13:0] temp_offset_reg;
    logic signed [14:0] hum_offset_reg;

    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;

    logic [30:0] t_prod1_reg;
    logic [29:0] h_prod1_reg;
    logic [7:0]  t_crc1_reg, h_crc1_reg;
    logic [7:0]  t_lo1_reg, h_lo1_reg;
    logic [7:0]  t_chk1_reg, h_chk1_reg;

    logic [14:0] t_q2_reg;
    logic [13:0] h_q2_reg;
    logic        err2_reg;

    logic signed [15:0] temperature_reg;
    logic [13:0]        humidity_reg;
    logic               check_error_reg;

    logic [30:0] t_n;
    logic [29:0] h_n;
    logic [16:0] t_r, h_r;
    logic [14:0] t_q;
    logic [13:0] h_q;
    logic        err_next;

    logic signed [16:0] t_sum, h_sum;
    logic [13:0]        h_clip;

    // APB
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_offset_reg <= '0;
            hum_offset_reg  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_TEMP_OFFSET: temp_offset_reg <= pwdata[13:0];
                REG_HUM_OFFSET:  hum_offset_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEMP_OFFSET: prdata = 32'(temp_offset_reg);
            REG_HUM_OFFSET:  prdata = 32'(hum_offset_reg);
            default:         prdata = '0;
        endcase
    end

    // Flow control
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: scale by span, first CRC byte
    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            t_prod1_reg <= 31'(s_temp_raw) * 31'(TEMP_SPAN);
            h_prod1_reg <= 30'(s_hum_raw) * 30'(HUM_SPAN);
            t_crc1_reg  <= crc8_byte(CRC_INIT, s_temp_raw[15:8]);
            h_crc1_reg  <= crc8_byte(CRC_INIT, s_hum_raw[15:8]);
            t_lo1_reg   <= s_temp_raw[7:0];
            h_lo1_reg   <= s_hum_raw[7:0];
            t_chk1_reg  <= s_temp_check;
            h_chk1_reg  <= s_hum_check;
        end
    end

    // Stage 2: round and divide by 65535, second CRC byte
    always_comb begin
        t_n = t_prod1_reg + 31'(ROUND_BIAS);
        h_n = h_prod1_reg + 30'(ROUND_BIAS);
        t_r = 17'(t_n[15:0]) + 17'(t_n[30:16]);
        h_r = 17'(h_n[15:0]) + 17'(h_n[29:16]);
        t_q = t_n[30:16] + 15'(t_r >= FULL_SCALE);
        h_q = h_n[29:16] + 14'(h_r >= FULL_SCALE);
        err_next = (crc8_byte(t_crc1_reg, t_lo1_reg) != t_chk1_reg) ||
                   (crc8_byte(h_crc1_reg, h_lo1_reg) != h_chk1_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            t_q2_reg <= t_q;
            h_q2_reg <= h_q;
            err2_reg <= err_next;
        end
    end

    // Stage 3: offsets and clip
    always_comb begin
        t_sum = $signed({2'b00, t_q2_reg}) + 17'(temp_offset_reg) + TEMP_BASE;
        h_sum = $signed({3'b000, h_q2_reg}) + 17'(hum_offset_reg);
        if (h_sum < 17'sd0) begin
            h_clip = '0;
        end else if (h_sum > HUM_MAX) begin
            h_clip = HUM_MAX[13:0];
        end else begin
            h_clip = h_sum[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3 && v2_reg) begin
            temperature_reg <= t_sum[15:0];
            humidity_reg    <= h_clip;
            check_error_reg <= err2_reg;
        end
    end

    assign m_valid       = v3_reg;
    assign m_temperature = temperature_reg;
    assign m_humidity    = humidity_reg;
    assign m_check_error = check_error_reg;

    `HTFD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
    `HTFD_ASSERT(a_hum_range, aclk, aresetn, m_valid |-> (m_humidity <= HUM_MAX[13:0]))
    `HTFD_ASSERT(a_take_fills, aclk, aresetn, (s_valid && s_ready) |=> v1_reg)
    `HTFD_ASSERT(a_stall_holds, aclk, aresetn, (v1_reg && !adv2) |-> !s_ready)

endmodule

// ===== dv/tb_humidity_temp_frame_decoder.sv =====
// Testbench for humidity_temp_frame_decoder: sends sensor frames, writes the offset
// registers over APB and checks every reading against a scoreboard prediction.
// Depends on htfd_pkg and the humidity_temp_frame_decoder RTL.
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam int SPAN_TEMP = 17500;
    localparam int SPAN_HUM  = 10000;
    localparam int BASE_TEMP = -4500;
    localparam int HUM_CEIL  = 10000;
    localparam int WORD_FULL = 65535;

    localparam logic [7:0] CRC8_POLY = 8'h31;
    localparam logic [7:0] CRC8_SEED = 8'hFF;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [7:0]  temp_check;
        logic [15:0] hum_raw;
        logic [7:0]  hum_check;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [13:0]        humidity;
        logic               check_error;
    } reading_t;

    typedef enum int {
        CRC_OK,
        CRC_BAD_TEMP,
        CRC_BAD_HUM,
        CRC_BAD_BOTH
    } crc_fault_t;

    // CRC-8 over a word, high byte first, bit by bit.
    function automatic logic [7:0] crc8_word(input logic [15:0] word);
        logic [7:0] crc;
        int i;
        crc = CRC8_SEED;
        for (i = 15; i >= 0; i--) begin
            crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ word[i]) ? CRC8_POLY : 8'h00);
        end
        return crc;
    endfunction

    // Round span*raw/65535 to nearest.
    function automatic int scale_word(input logic [15:0] raw, input int span);
        longint num;
        num = 2 * longint'(span) * longint'(raw) + WORD_FULL;
        return int'(num / (2 * WORD_FULL));
    endfunction

    class frame_scoreboard;
        reading_t           readings_due[$];
        logic signed [13:0] temp_offset;
        logic signed [14:0] hum_offset;
        int                 mismatches;

        function new();
            temp_offset = '0;
            hum_offset  = '0;
            mismatches  = 0;
        endfunction

        function void set_register(input logic index, input logic [31:0] value);
            if (index == htfd_pkg::REG_TEMP_OFFSET) begin
                temp_offset = value[13:0];
            end else begin
                hum_offset = value[14:0];
            end
        endfunction

        function void note_frame(input frame_t f);
            reading_t r;
            int t;
            int h;
            t = BASE_TEMP + scale_word(f.temp_raw, SPAN_TEMP) + int'(temp_offset);
            h = scale_word(f.hum_raw, SPAN_HUM) + int'(hum_offset);
            if (h < 0) begin
                h = 0;
            end else if (h > HUM_CEIL) begin
                h = HUM_CEIL;
            end
            r.temperature = t[15:0];
            r.humidity    = h[13:0];
            r.check_error = (crc8_word(f.temp_raw) != f.temp_check) ||
                            (crc8_word(f.hum_raw) != f.hum_check);
            readings_due.push_back(r);
        endfunction

        function void flag(input string what, input reading_t want, input reading_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s: want temp %0d hum %0d err %0b, got temp %0d hum %0d err %0b",
                         $time, what, $signed(want.temperature), want.humidity,
                         want.check_error, $signed(got.temperature), got.humidity,
                         got.check_error);
            end
        endfunction

        function void check_reading(input reading_t got);
            reading_t want;
            if (readings_due.size() == 0) begin
                flag("reading with no request pending", '0, got);
                return;
            end
            want = readings_due.pop_front();
            if (got.temperature !== want.temperature || got.humidity !== want.humidity ||
                got.check_error !== want.check_error) begin
                flag("reading mismatch", want, got);
            end
        endfunction

        function int failures();
            return mismatches + readings_due.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [15:0]        s_temp_raw;
    logic [7:0]         s_temp_check;
    logic [15:0]        s_hum_raw;
    logic [7:0]         s_hum_check;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_temperature;
    logic [13:0]        m_humidity;
    logic               m_check_error;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    frame_scoreboard sb = new();

    humidity_temp_frame_decoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temp_raw    (s_temp_raw),
        .s_temp_check  (s_temp_check),
        .s_hum_raw     (s_hum_raw),
        .s_hum_check   (s_hum_check),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_temperature (m_temperature),
        .m_humidity    (m_humidity),
        .m_check_error (m_check_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_frame('{s_temp_raw, s_temp_check, s_hum_raw, s_hum_check});
            end
            if (m_valid && m_ready) begin
                sb.check_reading('{m_temperature, m_humidity, m_check_error});
            end
        end
    end

    // Result side: random stall bursts, plus one long hold on request.
    initial begin : receiver
        int n;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 24);
                repeat (n) @(posedge aclk);
            end
        end
    end

    function automatic frame_t make_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                                          input crc_fault_t fault);
        frame_t f;
        f.temp_raw   = t_raw;
        f.hum_raw    = h_raw;
        f.temp_check = crc8_word(t_raw);
        f.hum_check  = crc8_word(h_raw);
        if (fault == CRC_BAD_TEMP || fault == CRC_BAD_BOTH) begin
            f.temp_check ^= 8'($urandom_range(1, 255));
        end
        if (fault == CRC_BAD_HUM || fault == CRC_BAD_BOTH) begin
            f.hum_check ^= 8'($urandom_range(1, 255));
        end
        return f;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic frame_t random_frame();
        crc_fault_t fault;
        case ($urandom_range(0, 9))
            7: fault = CRC_BAD_TEMP;
            8: fault = CRC_BAD_HUM;
            9: fault = CRC_BAD_BOTH;
            default: fault = CRC_OK;
        endcase
        return make_frame(pick_word(), pick_word(), fault);
    endfunction

    // Hold the request until it is taken; valid stays high for a following push.
    task automatic push_frame(input frame_t f);
        s_valid      <= 1'b1;
        s_temp_raw   <= f.temp_raw;
        s_temp_check <= f.temp_check;
        s_hum_raw    <= f.hum_raw;
        s_hum_check  <= f.hum_check;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 16);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic push_random(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (tx_gaps && $urandom_range(0, 3) == 0) begin
                idle_gap();
            end
            push_frame(random_frame());
        end
    endtask

    task automatic push_extremes();
        push_frame(make_frame(16'h0000, 16'h0000, CRC_OK));
        push_frame(make_frame(16'hFFFF, 16'hFFFF, CRC_OK));
        push_frame(make_frame(16'h8000, 16'h7FFF, CRC_BAD_BOTH));
        push_frame(make_frame(16'($urandom), 16'($urandom), CRC_OK));
    endtask

    // Wait out every pending reading, then let the pipeline go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.readings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_register(index, value);
    endtask

    task automatic configure(input int t_off, input int h_off);
        apb_write(htfd_pkg::REG_TEMP_OFFSET, 32'(t_off));
        apb_write(htfd_pkg::REG_HUM_OFFSET, 32'(h_off));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int p;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_temp_raw   <= '0;
        s_temp_check <= '0;
        s_hum_raw    <= '0;
        s_hum_check  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset offsets: word extremes, CRC faults, odd check bytes
        push_frame(make_frame(16'h0000, 16'h0000, CRC_OK));
        push_frame(make_frame(16'hFFFF, 16'hFFFF, CRC_OK));
        push_frame(make_frame(16'h0001, 16'hFFFE, CRC_OK));
        push_frame(make_frame(16'h7FFF, 16'h8000, CRC_OK));
        push_frame(make_frame(16'h8000, 16'h7FFF, CRC_OK));
        push_frame(make_frame(16'h5555, 16'hAAAA, CRC_OK));
        push_frame(make_frame(16'hAAAA, 16'h5555, CRC_BAD_TEMP));
        push_frame(make_frame(16'h1234, 16'hBEEF, CRC_BAD_HUM));
        push_frame(make_frame(16'hFFFF, 16'h0000, CRC_BAD_BOTH));
        push_frame('{16'h0000, 8'h00, 16'hFFFF, 8'hFF});
        push_frame('{16'hFFFF, 8'hFF, 16'h0000, 8'h00});
        settle();

        configure(-8192, -16384);
        push_extremes();
        settle();
        configure(8191, 16383);
        push_extremes();
        settle();
        configure(-5000, -10000);
        push_random(20);
        settle();

        for (p = 0; p < 7; p++) begin
            configure(int'($urandom_range(0, 16383)) - 8192,
                      int'($urandom_range(0, 32767)) - 16384);
            push_random(100);
            settle();
        end

        // long result-side hold while requests keep coming
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        push_random(40);
        settle();

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        configure(5000, 10000);
        push_random(100);
        settle();

        if (sb.failures() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== humidity_temp_frame_decoder.f =====
+incdir+rtl/core
rtl/core/htfd_pkg.sv
rtl/core/humidity_temp_frame_decoder.sv
dv/tb_humidity_temp_frame_decoder.sv
